// ----- rtl/stereo_sample_ring_buffer_top_assert.svh -----
// ----------------------------------------------------------------------------
// Stereo sample ring buffer: assertion macros
// Shared property forms for the checker attached to the top level.
// ----------------------------------------------------------------------------
`ifndef STEREO_SAMPLE_RING_BUFFER_TOP_ASSERT_SVH
`define STEREO_SAMPLE_RING_BUFFER_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent, outside reset.
`define SSRB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent, outside reset.
`define SSRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// Same-cycle check that stays armed through reset.
`define SSRB_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
	label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/ssrb_pkg.sv -----
// ----------------------------------------------------------------------------
// ssrb_pkg
// Types and fixed constants of the stereo sample ring buffer.
// ----------------------------------------------------------------------------
package ssrb_pkg;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		REG_CHANNEL_COUNT = 2'd0,
		REG_SAMPLE_BITS   = 2'd1,
		REG_FLOAT_FORMAT  = 2'd2
	} reg_idx_t;

	typedef enum logic {
		KIND_WRITE = 1'b0,
		KIND_READ  = 1'b1
	} kind_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] left_raw;
		logic [31:0] right_raw;
		logic        batch_end;
		logic [9:0]  window_size;
		logic [9:0]  sample_index;
	} in_word_t;

	typedef struct packed {
		logic signed [7:0] left_sample;
		logic signed [7:0] right_sample;
		logic              window_last;
		logic              zero_filled;
	} out_word_t;

	// One queued job for the back end
	typedef struct packed {
		kind_t      kind;
		logic [7:0] left_data;
		logic [7:0] right_data;
		logic       last;
		logic       zero;
	} job_t;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [3:0] CHANNEL_COUNT_RST = 4'd2;
	localparam logic [5:0] SAMPLE_BITS_RST   = 6'd16;
	localparam logic       FLOAT_FORMAT_RST  = 1'b0;

	localparam logic [5:0] MIN_BITS   = 6'd8;
	localparam logic [5:0] INT_BITS   = 6'd16;
	localparam logic [5:0] FLOAT_BITS = 6'd32;

	localparam logic signed [7:0] SAMPLE_MAX  = 8'sd127;
	localparam logic signed [7:0] SAMPLE_MIN  = 8'sh80;
	localparam logic [7:0]        FLOAT_SCALE = 8'd127;
	localparam logic [7:0]        EXP_ONE     = 8'd127;
	localparam logic [7:0]        EXP_MAX     = 8'hFF;
	localparam logic [8:0]        EXP_SHIFT   = 9'd150;

endpackage

// ----- rtl/ssrb_queue.sv -----
// ----------------------------------------------------------------------------
// ssrb_queue
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module ssrb_queue #(
	parameter int DEPTH = 576,
	localparam int PW = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ssrb_pkg::job_t  push_job,
	input  logic [PW-1:0]   push_addr,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output ssrb_pkg::job_t  head_job,
	output logic [PW-1:0]   head_addr
);
	import ssrb_pkg::*;

	localparam int QP = $clog2(QUEUE_DEPTH);
	localparam int QC = $clog2(QUEUE_DEPTH + 1);

	job_t          job_q  [QUEUE_DEPTH];
	logic [PW-1:0] addr_q [QUEUE_DEPTH];
	logic [QP-1:0] wr_ptr_q;
	logic [QP-1:0] rd_ptr_q;
	logic [QC-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full       = (count_q == QC'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = job_q[rd_ptr_q];
	assign head_addr  = addr_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			job_q[wr_ptr_q]  <= push_job;
			addr_q[wr_ptr_q] <= push_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// ----- rtl/ssrb_front.sv -----
// ----------------------------------------------------------------------------
// ssrb_front
// Accepts words, converts samples, keeps ring pointers and window state.
// ----------------------------------------------------------------------------
module ssrb_front #(
	parameter int DEPTH = 576,
	localparam int PW = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  ssrb_pkg::in_word_t   in_word,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [5:0]           cfg_data,
	input  logic                 q_full,
	output logic                 push,
	output ssrb_pkg::job_t       push_job,
	output logic [PW-1:0]        push_addr
);
	import ssrb_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = ((CW > 10) ? CW : 10) + 2;

	logic [3:0]    chan_q;
	logic [5:0]    bits_q;
	logic          float_q;
	logic [PW-1:0] oldest_q, oldest_d;
	logic [CW-1:0] fill_q, fill_d;
	logic          drained_q, drained_d;
	logic [PW-1:0] base_q, base_d;
	logic          wzero_q, wzero_d;

	logic          accept;
	logic [XW-1:0] sum_x;
	logic [XW-1:0] wbase_x;
	logic [XW-1:0] raddr_x;
	logic [9:0]    sidx_mod;
	logic [PW-1:0] eff_base;
	logic          eff_zero;
	logic          in_window;
	logic          is_last;
	logic [7:0]    left_cv;
	logic [7:0]    right_cv;

	// Reduce a window index into ring range by conditional subtraction
	function automatic logic [9:0] wrap_index(input logic [9:0] x);
		logic [9:0] r;
		r = x;
		for (int k = 6; k >= 0; k--) begin
			if ((DEPTH << k) <= 1023) begin
				if (int'(r) >= (DEPTH << k)) r = r - 10'(DEPTH << k);
			end
		end
		return r;
	endfunction

	function automatic logic [7:0] conv_int16(input logic [31:0] raw);
		logic signed [15:0] v;
		logic signed [15:0] q;
		v = raw[15:0];
		q = v >>> 8;
		if (raw[15] && (raw[7:0] != 8'd0)) q = q + 16'sd1;
		return q[7:0];
	endfunction

	function automatic logic [7:0] conv_float(input logic [31:0] raw);
		logic        neg;
		logic [7:0]  ex;
		logic [22:0] man;
		logic [23:0] m;
		logic [8:0]  sh;
		logic [30:0] prod;
		logic [7:0]  mag;
		logic [7:0]  res;
		neg  = raw[31];
		ex   = raw[30:23];
		man  = raw[22:0];
		m    = (ex == 8'd0) ? {1'b0, man} : {1'b1, man};
		sh   = (ex == 8'd0) ? 9'd149 : (EXP_SHIFT - {1'b0, ex});
		prod = 31'(m) * 31'(FLOAT_SCALE);
		mag  = (sh >= 9'd32) ? 8'd0 : 8'(prod >> sh[4:0]);
		if (ex == EXP_MAX && man != '0) res = 8'd0;
		else if (!neg && ex >= EXP_ONE) res = SAMPLE_MAX;
		else if (neg && (ex > EXP_ONE || (ex == EXP_ONE && man != '0))) res = SAMPLE_MIN;
		else if (neg) res = 8'd0 - mag;
		else res = mag;
		return res;
	endfunction

	function automatic logic [7:0] convert(input logic [31:0] raw, input logic fl,
			input logic [5:0] nbits);
		logic [7:0] r;
		r = 8'd0;
		if (fl) begin
			if (nbits == FLOAT_BITS) r = conv_float(raw);
		end else begin
			if (nbits == INT_BITS) r = conv_int16(raw);
		end
		return r;
	endfunction

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	assign left_cv  = convert(in_word.left_raw, float_q, bits_q);
	assign right_cv = (chan_q >= 4'd2) ? convert(in_word.right_raw, float_q, bits_q) : left_cv;

	// Window snapshot arithmetic
	assign sum_x    = XW'(oldest_q) + XW'(fill_q);
	assign wbase_x  = sum_x - XW'(in_word.window_size);
	assign sidx_mod = wrap_index(in_word.sample_index);
	assign raddr_x  = XW'(eff_base) + XW'(sidx_mod);

	always_comb begin
		oldest_d  = oldest_q;
		fill_d    = fill_q;
		drained_d = drained_q;
		base_d    = base_q;
		wzero_d   = wzero_q;
		push      = 1'b0;
		push_job  = '{kind: KIND_WRITE, left_data: left_cv, right_data: right_cv,
			last: 1'b0, zero: 1'b0};
		push_addr = '0;
		eff_base  = base_q;
		eff_zero  = wzero_q;
		in_window = 1'b0;
		is_last   = 1'b0;
		if (accept) begin
			unique case (in_word.command)
				CMD_WRITE: begin
					if (chan_q != 4'd0 && bits_q >= MIN_BITS) begin
						push = 1'b1;
						push_addr = (sum_x >= XW'(DEPTH)) ? PW'(sum_x - XW'(DEPTH))
							: PW'(sum_x);
						if (fill_q != CW'(DEPTH)) fill_d = fill_q + 1'b1;
						else oldest_d = (oldest_q == PW'(DEPTH - 1)) ? '0 : oldest_q + 1'b1;
						if (in_word.batch_end) drained_d = 1'b0;
					end
				end
				CMD_READ: begin
					// Index zero takes a fresh snapshot of the window
					if (in_word.sample_index == 10'd0) begin
						eff_zero = (in_word.window_size == 10'd0) ||
							(XW'(fill_q) < XW'(in_word.window_size)) || drained_q;
						if (!eff_zero) begin
							eff_base = (wbase_x >= XW'(DEPTH)) ? PW'(wbase_x - XW'(DEPTH))
								: PW'(wbase_x);
						end
						wzero_d = eff_zero;
						base_d  = eff_base;
					end
					in_window = (in_word.sample_index < in_word.window_size);
					is_last   = in_window && (in_word.sample_index + 10'd1 == in_word.window_size);
					push = 1'b1;
					push_job.kind = KIND_READ;
					push_job.last = is_last;
					push_job.zero = !in_window || eff_zero;
					push_addr = (raddr_x >= XW'(DEPTH)) ? PW'(raddr_x - XW'(DEPTH))
						: PW'(raddr_x);
					if (in_window && !eff_zero && is_last) drained_d = 1'b1;
				end
				CMD_CLEAR: begin
					oldest_d  = '0;
					fill_d    = '0;
					drained_d = 1'b0;
					wzero_d   = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q    <= CHANNEL_COUNT_RST;
			bits_q    <= SAMPLE_BITS_RST;
			float_q   <= FLOAT_FORMAT_RST;
			oldest_q  <= '0;
			fill_q    <= '0;
			drained_q <= 1'b0;
			base_q    <= '0;
			wzero_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_CHANNEL_COUNT: chan_q  <= cfg_data[3:0];
					REG_SAMPLE_BITS:   bits_q  <= cfg_data;
					REG_FLOAT_FORMAT:  float_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
			oldest_q  <= oldest_d;
			fill_q    <= fill_d;
			drained_q <= drained_d;
			base_q    <= base_d;
			wzero_q   <= wzero_d;
		end
	end

endmodule

// ----- rtl/ssrb_back.sv -----
// ----------------------------------------------------------------------------
// ssrb_back
// Sample store, registered read and the output register.
// ----------------------------------------------------------------------------
module ssrb_back #(
	parameter int DEPTH = 576,
	localparam int PW = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  ssrb_pkg::job_t      q_job,
	input  logic [PW-1:0]       q_addr,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output ssrb_pkg::out_word_t out_word
);
	import ssrb_pkg::*;

	logic [15:0] mem_q [DEPTH];
	logic [15:0] rdata_s1;
	logic        valid_s1;
	logic        last_s1;
	logic        zero_s1;
	logic        s1_move;
	logic        pop_wr;
	logic        pop_rd;
	logic        out_valid_q;
	out_word_t   out_word_q;

	assign s1_move = valid_s1 && (!out_valid_q || !out_stall);
	assign q_pop   = q_valid && (q_job.kind == KIND_WRITE || !valid_s1 || s1_move);
	assign pop_wr  = q_pop && (q_job.kind == KIND_WRITE);
	assign pop_rd  = q_pop && (q_job.kind == KIND_READ);

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	always_ff @(posedge clk) begin
		if (pop_wr) mem_q[q_addr] <= {q_job.left_data, q_job.right_data};
		if (pop_rd) begin
			rdata_s1 <= mem_q[q_addr];
			last_s1  <= q_job.last;
			zero_s1  <= q_job.zero;
		end
		if (s1_move) begin
			out_word_q.left_sample  <= zero_s1 ? 8'sd0 : rdata_s1[15:8];
			out_word_q.right_sample <= zero_s1 ? 8'sd0 : rdata_s1[7:0];
			out_word_q.window_last  <= last_s1;
			out_word_q.zero_filled  <= zero_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop_rd) valid_s1 <= 1'b1;
			else if (s1_move) valid_s1 <= 1'b0;
			if (s1_move) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- rtl/stereo_sample_ring_buffer_top.sv -----
// ----------------------------------------------------------------------------
// stereo_sample_ring_buffer_top
// Stereo capture ring of signed 8-bit sample pairs with windowed read-out.
// ----------------------------------------------------------------------------
//
//   channel | signals                          | moves
//   --------+----------------------------------+------------------------------
//   input   | in_valid, in_stall, in_word      | write, read or clear command
//   output  | out_valid, out_stall, out_word   | one sample pair per read
//   config  | cfg_we, cfg_index, cfg_data      | register write, no read-back
//
// One input word is taken per cycle while the four-entry job queue has room;
// in_stall is simply the queue being full.
// A read word passes through the queue, the store read register and the
// output register, in that order, before it leaves.
// The store has a single port, so the back end takes one queued write or
// read at a time; writes drain even while the output is stalled.
// Reset clears pointers, fill count, drained and window state and returns the
// config registers to defaults; the store is not cleared and needs no sweep.
//
module stereo_sample_ring_buffer_top #(
	parameter int DEPTH = 576
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  ssrb_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_stall,
	output ssrb_pkg::out_word_t out_word,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [5:0]          cfg_data
);
	import ssrb_pkg::*;

	localparam int PW = $clog2(DEPTH);

	// Front to queue
	logic          push;
	job_t          push_job;
	logic [PW-1:0] push_addr;
	logic          q_full;

	// Queue to back
	logic          head_valid;
	job_t          head_job;
	logic [PW-1:0] head_addr;
	logic          pop;

	// Front end: classify the word, convert samples, advance ring pointers
	// and take the window snapshot; only writes and reads become jobs.
	ssrb_front #(.DEPTH(DEPTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.push      (push),
		.push_job  (push_job),
		.push_addr (push_addr)
	);

	// Hold jobs so that the front keeps accepting while the output stalls
	ssrb_queue #(.DEPTH(DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.push_addr  (push_addr),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job),
		.head_addr  (head_addr)
	);

	// Back end: write or read the store, drop data of zero-filled reads
	ssrb_back #(.DEPTH(DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (head_valid),
		.q_job     (head_job),
		.q_addr    (head_addr),
		.q_pop     (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule

// ----- rtl/ssrb_checker.sv -----
// ----------------------------------------------------------------------------
// ssrb_checker
// Port-level checks on the stereo sample ring buffer.
// ----------------------------------------------------------------------------
`include "stereo_sample_ring_buffer_top_assert.svh"

module ssrb_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input ssrb_pkg::out_word_t out_word
);
	import ssrb_pkg::*;

	// A stalled word stays put
	`SSRB_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_word), "stalled output word changed")

	// Zero-filled words carry zero samples
	`SSRB_ASSERT_NOW(a_zero_data, clk, arst_n, out_valid && out_word.zero_filled, out_word.left_sample == 8'sd0 && out_word.right_sample == 8'sd0, "zero-filled word with sample data")

	// Nothing is offered while reset is held
	`SSRB_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n, !out_valid, "output valid during reset")

endmodule

bind stereo_sample_ring_buffer_top ssrb_checker u_ssrb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word)
);
